FILE: hdl/assert_macros.svh
// Assertion helpers shared by the frame builder modules.
// They expect a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of aclk outside of reset.
`define ABFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ABFB_NEVER(lbl, cond, msg) \
    `ABFB_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/abfb_pkg.sv
package abfb_pkg;

    // Input item tdata: motor_index, wheel_speed, kick_enable, chip_kick, kick_strength.
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 8;
    localparam int BODY_W      = 56;
    localparam int POS_W       = 4;

    localparam logic MODE_MOTOR = 1'b0;
    localparam logic MODE_KICK  = 1'b1;

    localparam logic [7:0] SYNC_FIRST    = 8'hFA;
    localparam logic [7:0] SYNC_SECOND   = 8'hAF;
    localparam logic [7:0] MOTOR_BASE_ID = 8'h10;
    localparam logic [7:0] KICK_ID       = 8'h20;
    localparam logic [7:0] MOTOR_ADDR    = 8'h00;
    localparam logic [7:0] STRAIGHT_ADDR = 8'h01;
    localparam logic [7:0] CHIP_ADDR     = 8'h02;
    localparam logic [7:0] MOTOR_LEN     = 8'h04;
    localparam logic [7:0] KICK_LEN      = 8'h02;
    localparam logic [7:0] POWER_MAX     = 8'd11;

    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = 4'd1;
    localparam logic [POS_W-1:0] MOTOR_LAST_POS  = 4'd9;
    localparam logic [POS_W-1:0] KICK_LAST_POS   = 4'd7;

    typedef struct packed {
        logic        mode;
        logic [1:0]  motor_index;
        logic [31:0] wheel_speed;
        logic [7:0]  kick_enable;
        logic        chip_kick;
        logic [7:0]  kick_strength;
    } cmd_t;

    typedef struct packed {
        logic       busy;
        logic       last;
        logic [7:0] tx_byte;
    } ser_status_t;

endpackage

FILE: hdl/abfb_serializer.sv
`include "assert_macros.svh"

module abfb_serializer
    import abfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  cmd_t        cmd,
    input  logic        step,
    output ser_status_t status
);

    logic              busy_reg,    busy_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [7:0]        parity_reg,  parity_next;
    logic [BODY_W-1:0] shift_reg,   shift_next;

    logic [BODY_W-1:0] load_body;
    logic [7:0]        enable_sat;
    logic [7:0]        power_sat;
    logic              is_last;
    logic              is_body;
    logic [7:0]        cur_byte;

    // Frame body from the id byte on, lowest byte sent first.
    always_comb begin
        enable_sat = (cmd.kick_enable != 8'd0) ? 8'd1 : 8'd0;
        power_sat  = (cmd.kick_strength > POWER_MAX) ? POWER_MAX : cmd.kick_strength;
        if (cmd.mode == MODE_MOTOR) begin
            load_body = {cmd.wheel_speed, MOTOR_LEN, MOTOR_ADDR,
                         MOTOR_BASE_ID + {6'd0, cmd.motor_index}};
        end else begin
            load_body = {16'd0, power_sat, enable_sat, KICK_LEN,
                         cmd.chip_kick ? CHIP_ADDR : STRAIGHT_ADDR, KICK_ID};
        end
    end

    always_comb begin
        is_last = (pos_reg == last_pos_reg);
        is_body = (pos_reg != POS_SYNC_FIRST) && (pos_reg != POS_SYNC_SECOND) && !is_last;
        case (pos_reg)
            POS_SYNC_FIRST:  cur_byte = SYNC_FIRST;
            POS_SYNC_SECOND: cur_byte = SYNC_SECOND;
            default:         cur_byte = is_last ? parity_reg : shift_reg[7:0];
        endcase
    end

    always_comb begin
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        last_pos_next = last_pos_reg;
        parity_next   = parity_reg;
        shift_next    = shift_reg;
        if (load) begin
            busy_next     = 1'b1;
            pos_next      = POS_SYNC_FIRST;
            last_pos_next = (cmd.mode == MODE_MOTOR) ? MOTOR_LAST_POS : KICK_LAST_POS;
            parity_next   = 8'd0;
            shift_next    = load_body;
        end else if (step && busy_reg) begin
            pos_next = pos_reg + 4'd1;
            if (is_body) begin
                parity_next = parity_reg ^ shift_reg[7:0];
                shift_next  = {8'd0, shift_reg[BODY_W-1:8]};
            end
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_SYNC_FIRST;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
        last_pos_reg <= last_pos_next;
        parity_reg   <= parity_next;
        shift_reg    <= shift_next;
    end

    assign status.busy    = busy_reg;
    assign status.last    = busy_reg && is_last;
    assign status.tx_byte = cur_byte;

    `ABFB_ASSERT(a_pos_in_frame, busy_reg |-> (pos_reg <= last_pos_reg), "position past frame end")
    `ABFB_ASSERT(a_last_ends_frame, (step && status.last && !load) |=> !busy_reg, "no frame end")
    `ABFB_NEVER(a_load_while_busy, load && busy_reg, "command loaded during a frame")

endmodule

FILE: hdl/actuator_bus_frame_builder.sv
// Actuator bus frame builder. Each accepted command item becomes one serial
// bus frame, sent as one result item per byte on the m_ side: the sync bytes
// 0xFA 0xAF, device id, register address, payload length, the payload and
// an XOR parity byte over id, address, length and payload, with m_tlast high
// on the parity byte. A motor command (s_tuser low) gives a ten-byte frame
// carrying the signed rpm low byte first; a kick command (s_tuser high) gives
// an eight-byte frame with enable saturated to 1 and power saturated to 11.
// The serializer produces one byte per cycle while the output register can
// take it, shifting a 56-bit body register down one byte at a time; m_tready
// low while the output register is full holds the serializer back. The
// accepted command is loaded into the serializer before its first sync byte.
// Commands are handled one at a time: the next item can be taken in the
// cycle after the parity byte moves into the output register, while that
// byte may still wait to be taken.

`include "assert_macros.svh"

module actuator_bus_frame_builder
    import abfb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Bits from lowest: motor_index[1:0], wheel_speed[33:2], kick_enable[41:34],
    // chip_kick[42], kick_strength[50:43], zero fill[55:51].
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // Bits from lowest: mode.
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Bits from lowest: tx_byte[7:0].
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    cmd_t        cmd;
    ser_status_t ser_status;
    logic        s_accept;
    logic        out_free;
    logic        ser_step;
    logic        sync_ready;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                   m_tlast_reg,  m_tlast_next;

    // Unpack the command item.
    assign cmd.mode          = s_tuser;
    assign cmd.motor_index   = s_tdata[1:0];
    assign cmd.wheel_speed   = s_tdata[33:2];
    assign cmd.kick_enable   = s_tdata[41:34];
    assign cmd.chip_kick     = s_tdata[42];
    assign cmd.kick_strength = s_tdata[50:43];

    // The serializer takes a new command only when it holds no frame.
    assign s_tready = !ser_status.busy;
    assign s_accept = s_tvalid && s_tready;

    // A byte moves into the output register when it is empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign ser_step = ser_status.busy && out_free;

    abfb_serializer u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_accept),
        .cmd     (cmd),
        .step    (ser_step),
        .status  (ser_status)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (ser_step) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = ser_status.tx_byte;
            m_tlast_next  = ser_status.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign sync_ready = ser_status.busy && (ser_status.tx_byte == SYNC_FIRST);

    // Every accepted command starts its frame with the first sync byte.
    `ABFB_ASSERT(a_frame_starts_sync, s_accept |=> sync_ready, "frame does not start with sync")
    // The parity flag is only raised while a frame is in progress.
    `ABFB_NEVER(a_last_only_busy, ser_status.last && !ser_status.busy, "last byte flagged while idle")
    // An output byte is overwritten only when the previous one was taken.
    `ABFB_ASSERT(a_no_overwrite, (m_tvalid && !m_tready) |-> !ser_step, "output byte overwritten")

endmodule
